// File: hdl/gncm_pkg.sv
`default_nettype none
package gncm_pkg;

	localparam int CORPUS_SLOTS_DEF = 256;
	localparam int COUNTER_BITS_DEF = 14;
	localparam int CORDIC_STEPS = 16;
	localparam int XW = 30;
	localparam int ZW = 28;
	localparam logic signed [XW-1:0] CORDIC_K_Q24 = 30'sd10188014;
	localparam logic signed [22:0] LOG2_TEN_Q24 = 23'sd2786635;
	localparam logic signed [XW-1:0] HALF_TURN_Q16 = 30'sd11796480;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_EVENT = 2'd1,
		REQ_TICK = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		CFG_LEVEL_THRESHOLD = 2'd0,
		CFG_MIN_INTERVAL = 2'd1,
		CFG_SMOOTHING = 2'd2,
		CFG_CORPUS_SIZE = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		CORDIC_ROTATE = 1'b0,
		CORDIC_VECTOR = 1'b1
	} cordic_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ROTATE,
		ST_SMOOTH_X,
		ST_SMOOTH_Y,
		ST_VEC_GO,
		ST_VECTOR,
		ST_OUTPUT
	} state_t;

	typedef struct packed {
		logic busy;
		logic found;
		logic [7:0] slot;
		logic [18:0] centroid;
	} scan_res_t;

	typedef struct packed {
		logic done;
		logic signed [17:0] ux;
		logic signed [17:0] uy;
		logic signed [14:0] angle;
	} cordic_res_t;

	typedef logic [15:0][30:0] root_tab_t;

	function automatic logic [ZW-1:0] atan_q16(input logic [3:0] i);
		case (i)
			4'd0: return 28'd2949120;
			4'd1: return 28'd1740967;
			4'd2: return 28'd919879;
			4'd3: return 28'd466945;
			4'd4: return 28'd234379;
			4'd5: return 28'd117304;
			4'd6: return 28'd58666;
			4'd7: return 28'd29335;
			4'd8: return 28'd14668;
			4'd9: return 28'd7334;
			4'd10: return 28'd3667;
			4'd11: return 28'd1833;
			4'd12: return 28'd917;
			4'd13: return 28'd458;
			4'd14: return 28'd229;
			4'd15: return 28'd115;
			default: return 28'd0;
		endcase
	endfunction

	// elaboration only: integer square root
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] rem;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		rem = v;
		for (int i = 0; i < 32; i++) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-k) in Q30, k = 1..16, entry k-1
	function automatic root_tab_t gain_roots();
		root_tab_t t;
		logic [63:0] r;
		r = 64'd1 << 30;
		for (int k = 0; k < 16; k++) begin
			if (k == 0) r = isqrt64(64'd1 << 61);
			else r = isqrt64(r << 30);
			t[k] = r[30:0];
		end
		return t;
	endfunction

	localparam root_tab_t GAIN_ROOT = gain_roots();

endpackage
`default_nettype wire

// File: hdl/gncm_if.sv
`default_nettype none
interface gncm_req_if;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic [7:0] slot;
	logic [18:0] entry_centroid;
	logic signed [15:0] entry_crest;
	logic signed [15:0] entry_tonality;
	logic signed [15:0] azimuth;
	logic [15:0] strength;
	logic signed [15:0] level;
	logic [18:0] frequency;
	modport source (output valid, req_type, slot, entry_centroid, entry_crest,
		entry_tonality, azimuth, strength, level, frequency, input ready);
	modport sink (input valid, req_type, slot, entry_centroid, entry_crest,
		entry_tonality, azimuth, strength, level, frequency, output ready);
endinterface

interface gncm_res_if;
	logic valid;
	logic ready;
	logic [7:0] match_slot;
	logic [18:0] match_centroid;
	logic [23:0] gain;
	logic [15:0] rho;
	logic signed [14:0] smoothed_azimuth;
	modport source (output valid, match_slot, match_centroid, gain, rho,
		smoothed_azimuth, input ready);
	modport sink (input valid, match_slot, match_centroid, gain, rho,
		smoothed_azimuth, output ready);
endinterface

interface gncm_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [16:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/gncm_scan.sv
`default_nettype none
module gncm_scan #(
	parameter int CORPUS_SLOTS = gncm_pkg::CORPUS_SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [7:0] wr_slot,
	input wire logic [18:0] wr_centroid,
	input wire logic wr_usable,
	input wire logic start,
	input wire logic [8:0] count,
	input wire logic [18:0] freq,
	output gncm_pkg::scan_res_t res
);
	import gncm_pkg::*;

	localparam int SW = $clog2(CORPUS_SLOTS);

	logic [18:0] mem [CORPUS_SLOTS];
	logic [CORPUS_SLOTS-1:0] usable_q;
	logic [SW:0] idx_q;
	logic [SW:0] n_q;
	logic issue_q;
	logic [18:0] freq_q;
	logic vld_s1;
	logic use_s1;
	logic [18:0] cent_s1;
	logic [SW-1:0] idx_s1;
	logic found_q;
	logic [SW-1:0] best_q;
	logic [18:0] bestc_q;
	logic [18:0] bestd_q;
	logic [18:0] gap;
	logic better;
	logic wr_ok;
	logic [SW:0] n_clamped;

	assign wr_ok = wr_en && (32'(wr_slot) < 32'(CORPUS_SLOTS));
	assign n_clamped = (32'(count) > 32'(CORPUS_SLOTS)) ? (SW+1)'(CORPUS_SLOTS)
		: (SW+1)'(count);

	always_ff @(posedge clk) begin
		if (wr_ok) mem[SW'(wr_slot)] <= wr_centroid;
		cent_s1 <= mem[idx_q[SW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q <= '0;
		end else if (wr_ok) begin
			usable_q[SW'(wr_slot)] <= wr_usable;
		end
	end

	assign gap = (cent_s1 > freq_q) ? cent_s1 - freq_q : freq_q - cent_s1;
	assign better = !found_q || (gap < bestd_q) || (gap == bestd_q && cent_s1 < bestc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			vld_s1 <= 1'b0;
			found_q <= 1'b0;
			idx_q <= '0;
			n_q <= '0;
		end else if (start) begin
			issue_q <= (n_clamped != '0);
			n_q <= n_clamped;
			idx_q <= '0;
			vld_s1 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= issue_q;
			if (issue_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q + 1'b1 == n_q) issue_q <= 1'b0;
			end
			if (vld_s1 && use_s1 && better) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) freq_q <= freq;
		use_s1 <= usable_q[idx_q[SW-1:0]];
		idx_s1 <= idx_q[SW-1:0];
		if (vld_s1 && use_s1 && better) begin
			best_q <= idx_s1;
			bestc_q <= cent_s1;
			bestd_q <= gap;
		end
	end

	assign res.busy = issue_q || vld_s1;
	assign res.found = found_q;
	assign res.slot = 8'(best_q);
	assign res.centroid = bestc_q;
endmodule
`default_nettype wire

// File: hdl/gncm_cordic.sv
`default_nettype none
module gncm_cordic (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire gncm_pkg::cordic_mode_t mode,
	input wire logic signed [15:0] az,
	input wire logic signed [17:0] vx,
	input wire logic signed [17:0] vy,
	output gncm_pkg::cordic_res_t res
);
	import gncm_pkg::*;

	logic busy_q;
	logic done_q;
	logic [4:0] step_q;
	cordic_mode_t mode_q;
	logic flip_q;
	logic zero_q;
	logic signed [XW-1:0] x_q, y_q, base_q;
	logic signed [ZW-1:0] z_q;
	logic signed [16:0] a0, a1;
	logic a_flip;
	logic signed [XW-1:0] px, py, pbase;
	logic signed [XW-1:0] dx, dy;
	logic [ZW-1:0] at;
	logic dir_pos;
	logic hold;
	logic signed [XW-1:0] rx, ry, rsum;

	// rotate: wrap to +-180 deg, fold into +-90 deg
	always_comb begin
		a0 = 17'(az);
		if (a0 > 17'sd11520) a0 = a0 - 17'sd23040;
		else if (a0 < -17'sd11520) a0 = a0 + 17'sd23040;
		a1 = a0;
		a_flip = 1'b0;
		if (a0 > 17'sd5760) begin
			a1 = a0 - 17'sd11520;
			a_flip = 1'b1;
		end else if (a0 < -17'sd5760) begin
			a1 = a0 + 17'sd11520;
			a_flip = 1'b1;
		end
		px = XW'(vx);
		py = XW'(vy);
		pbase = '0;
		if (vx < 0) begin
			pbase = (vy >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
			px = -px;
			py = -py;
		end
	end

	assign dx = x_q >>> step_q[3:0];
	assign dy = y_q >>> step_q[3:0];
	assign at = atan_q16(step_q[3:0]);
	assign dir_pos = (mode_q == CORDIC_ROTATE) ? (z_q >= 0) : (y_q > 0);
	assign hold = (mode_q == CORDIC_VECTOR) && (y_q == 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 5'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= mode;
			flip_q <= a_flip;
			zero_q <= (vx == 0) && (vy == 0);
			base_q <= pbase;
			if (mode == CORDIC_ROTATE) begin
				x_q <= CORDIC_K_Q24;
				y_q <= '0;
				z_q <= ZW'(a1) <<< 10;
			end else begin
				x_q <= px <<< 8;
				y_q <= py <<< 8;
				z_q <= '0;
			end
		end else if (busy_q && !hold) begin
			if (dir_pos == (mode_q == CORDIC_ROTATE)) begin
				x_q <= x_q - dy;
				y_q <= y_q + dx;
			end else begin
				x_q <= x_q + dy;
				y_q <= y_q - dx;
			end
			z_q <= dir_pos ? z_q - at : z_q + at;
			if (mode_q == CORDIC_VECTOR) z_q <= dir_pos ? z_q + at : z_q - at;
		end
	end

	always_comb begin
		rx = (x_q + XW'(128)) >>> 8;
		ry = (y_q + XW'(128)) >>> 8;
		if (flip_q) begin
			rx = -rx;
			ry = -ry;
		end
		if (rx > XW'(65536)) rx = XW'(65536);
		if (rx < -XW'(65536)) rx = -XW'(65536);
		if (ry > XW'(65536)) ry = XW'(65536);
		if (ry < -XW'(65536)) ry = -XW'(65536);
		rsum = (base_q + XW'(z_q) + XW'(512)) >>> 10;
		if (rsum > XW'(11520)) rsum = XW'(11520);
		if (rsum < -XW'(11520)) rsum = -XW'(11520);
		if (zero_q) rsum = '0;
	end

	assign res.done = done_q;
	assign res.ux = 18'(rx);
	assign res.uy = 18'(ry);
	assign res.angle = 15'(rsum);
endmodule
`default_nettype wire

// File: hdl/gncm_math.sv
`default_nettype none
module gncm_math (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [15:0] level,
	input wire logic [15:0] strength,
	output logic busy,
	output logic [23:0] gain,
	output logic [15:0] rho
);
	import gncm_pkg::*;

	logic busy_q;
	logic [4:0] step_q;
	logic signed [38:0] e_q;
	logic [30:0] m_q;
	logic [31:0] rem_q, root_q, bit_q;
	logic [23:0] gain_q;
	logic [61:0] prod;
	logic [31:0] trial;
	logic signed [6:0] n_exp;
	logic signed [7:0] sh8;
	logic [5:0] sh;
	logic [39:0] rnd;
	logic [23:0] gain_fin;

	assign prod = 62'(m_q) * 62'(GAIN_ROOT[step_q[3:0]]);
	assign trial = root_q + bit_q;

	// 2^n * m, rounded, n = integer part of the base-2 exponent
	always_comb begin
		n_exp = e_q[38:32];
		sh8 = 8'sd14 - 8'(n_exp);
		sh = sh8[5:0];
		rnd = (40'(m_q) + (40'd1 << (sh - 6'd1))) >> sh;
		if (n_exp >= 7'sd8) gain_fin = 24'hFF_FFFF;
		else if (rnd > 40'hFF_FFFF) gain_fin = 24'hFF_FFFF;
		else gain_fin = rnd[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == 5'd16) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			e_q <= 39'(level) * 39'(LOG2_TEN_Q24);
			m_q <= 31'(1) << 30;
			rem_q <= {strength, 16'h0000};
			root_q <= '0;
			bit_q <= 32'h4000_0000;
		end else if (busy_q) begin
			if (step_q[4]) begin
				gain_q <= gain_fin;
			end else begin
				if (e_q[6'd31 - 6'(step_q)]) m_q <= prod[60:30];
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end

	assign busy = busy_q;
	assign gain = gain_q;
	assign rho = root_q[15:0];
endmodule
`default_nettype wire

// File: hdl/gated_nearest_centroid_matcher.sv
// Load, tick, unknown and gated-off event requests are taken in idle and leave it idle.
// Passing event: slot scan over N slots (N = corpus_size capped at CORPUS_SLOTS), one
// memory read per cycle; no usable slot ends it, no result.
// A match adds two CORDIC passes and four control steps: result valid and input ready
// rise together, held off while an untaken result holds the output.
// Reset (arst_n low, async): config defaults, usable marks, counter all ones, direction 0.
`default_nettype none
module gated_nearest_centroid_matcher #(
	parameter int CORPUS_SLOTS = gncm_pkg::CORPUS_SLOTS_DEF,
	parameter int COUNTER_BITS = gncm_pkg::COUNTER_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	gncm_req_if.sink req,
	gncm_res_if.source res,
	gncm_cfg_if.sink cfg
);
	import gncm_pkg::*;

	// configuration registers
	logic signed [15:0] level_thr_q;
	logic [13:0] min_interval_q;
	logic [16:0] smoothing_q;
	logic [8:0] corpus_size_q;

	// block state
	logic [COUNTER_BITS-1:0] ticks_q;
	logic signed [17:0] dir_x_q, dir_y_q;
	logic signed [17:0] ux_q, uy_q;
	logic signed [15:0] az_q;
	logic signed [14:0] angle_q;
	state_t state_q, state_d;

	// output register
	logic res_vld_q;
	logic [7:0] res_slot_q;
	logic [18:0] res_cent_q;
	logic [23:0] res_gain_q;
	logic [15:0] res_rho_q;
	logic signed [14:0] res_angle_q;

	logic req_acc;
	logic is_load, is_tick, is_event;
	logic gate_pass;
	logic load_we, scan_start, rot_start, vec_start, out_load;
	cordic_mode_t cordic_mode;
	scan_res_t scan;
	cordic_res_t crd;
	logic math_busy;
	logic [23:0] gain_w;
	logic [15:0] rho_w;

	// smoothing datapath, one axis per cycle
	logic [16:0] s_eff, w_eff;
	logic signed [17:0] old_sel, unit_sel;
	logic signed [37:0] mix;
	logic signed [37:0] mix_sh;
	logic signed [17:0] mix_sat;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc = req.valid && req.ready;
	assign is_load = req.req_type == REQ_LOAD;
	assign is_tick = req.req_type == REQ_TICK;
	assign is_event = req.req_type == REQ_EVENT;

	// level gate, then rate gate
	assign gate_pass = !(req.level < level_thr_q)
		&& !(32'(ticks_q) < 32'(min_interval_q));

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_thr_q <= -16'sd10240;
			min_interval_q <= 14'd250;
			smoothing_q <= 17'd32768;
			corpus_size_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				CFG_LEVEL_THRESHOLD: level_thr_q <= cfg.data[15:0];
				CFG_MIN_INTERVAL: min_interval_q <= cfg.data[13:0];
				CFG_SMOOTHING: smoothing_q <= cfg.data;
				CFG_CORPUS_SIZE: corpus_size_q <= cfg.data[8:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (req_acc && is_event && gate_pass) state_d = ST_SCAN;
			ST_SCAN: begin
				if (!scan.busy) state_d = scan.found ? ST_ROTATE : ST_IDLE;
			end
			ST_ROTATE: if (crd.done) state_d = ST_SMOOTH_X;
			ST_SMOOTH_X: state_d = ST_SMOOTH_Y;
			ST_SMOOTH_Y: state_d = ST_VEC_GO;
			ST_VEC_GO: state_d = ST_VECTOR;
			ST_VECTOR: if (crd.done) state_d = ST_OUTPUT;
			ST_OUTPUT: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		load_we = 1'b0;
		scan_start = 1'b0;
		rot_start = 1'b0;
		vec_start = 1'b0;
		out_load = 1'b0;
		cordic_mode = CORDIC_ROTATE;
		case (state_q)
			ST_IDLE: begin
				load_we = req_acc && is_load;
				scan_start = req_acc && is_event && gate_pass;
			end
			ST_SCAN: rot_start = !scan.busy && scan.found;
			ST_VEC_GO: begin
				vec_start = 1'b1;
				cordic_mode = CORDIC_VECTOR;
			end
			ST_OUTPUT: out_load = !math_busy && (!res_vld_q || res.ready);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// elapsed ticks: saturating, cleared by an event that passes both gates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= '1;
		end else if (scan_start) begin
			ticks_q <= '0;
		end else if (req_acc && is_tick && ticks_q != '1) begin
			ticks_q <= ticks_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_start) az_q <= req.azimuth;
		if (state_q == ST_ROTATE && crd.done) begin
			ux_q <= crd.ux;
			uy_q <= crd.uy;
		end
		if (state_q == ST_VECTOR && crd.done) angle_q <= crd.angle;
	end

	// new = round((old*s + unit*(1-s)) / 2^16), s capped at 1.0
	assign s_eff = (smoothing_q > 17'd65536) ? 17'd65536 : smoothing_q;
	assign w_eff = 17'd65536 - s_eff;
	assign old_sel = (state_q == ST_SMOOTH_X) ? dir_x_q : dir_y_q;
	assign unit_sel = (state_q == ST_SMOOTH_X) ? ux_q : uy_q;

	always_comb begin
		mix = 38'(old_sel) * 38'($signed({1'b0, s_eff}))
			+ 38'(unit_sel) * 38'($signed({1'b0, w_eff})) + 38'sd32768;
		mix_sh = mix >>> 16;
		if (mix_sh > 38'sd131071) mix_sat = 18'sd131071;
		else if (mix_sh < -38'sd131072) mix_sat = -18'sd131072;
		else mix_sat = 18'(mix_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_x_q <= '0;
			dir_y_q <= '0;
		end else if (state_q == ST_SMOOTH_X) begin
			dir_x_q <= mix_sat;
		end else if (state_q == ST_SMOOTH_Y) begin
			dir_y_q <= mix_sat;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (out_load) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_slot_q <= scan.slot;
			res_cent_q <= scan.centroid;
			res_gain_q <= gain_w;
			res_rho_q <= rho_w;
			res_angle_q <= angle_q;
		end
	end

	assign res.valid = res_vld_q;
	assign res.match_slot = res_slot_q;
	assign res.match_centroid = res_cent_q;
	assign res.gain = res_gain_q;
	assign res.rho = res_rho_q;
	assign res.smoothed_azimuth = res_angle_q;

	gncm_scan #(
		.CORPUS_SLOTS(CORPUS_SLOTS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(load_we),
		.wr_slot(req.slot),
		.wr_centroid(req.entry_centroid),
		.wr_usable((req.entry_crest > 16'sd0) && (req.entry_tonality > 16'sd0)),
		.start(scan_start),
		.count(corpus_size_q),
		.freq(req.frequency),
		.res(scan)
	);

	// one CORDIC for both the azimuth unit vector and the smoothed angle
	gncm_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(rot_start || vec_start),
		.mode(cordic_mode),
		.az(az_q),
		.vx(dir_x_q),
		.vy(dir_y_q),
		.res(crd)
	);

	// gain and rho run alongside the scan
	gncm_math u_math (
		.clk(clk),
		.arst_n(arst_n),
		.start(scan_start),
		.level(req.level),
		.strength(req.strength),
		.busy(math_busy),
		.gain(gain_w),
		.rho(rho_w)
	);
endmodule
`default_nettype wire

// File: hdl/gncm_checker.sv
`default_nettype none
module gncm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic [1:0] req_type,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic [7:0] res_slot,
	input wire logic signed [14:0] res_angle
);
	import gncm_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_slot) && $stable(res_angle))
		else $error("result changed while stalled");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_angle <= 15'sd11520) && (res_angle >= -15'sd11520))
		else $error("angle out of range");

	a_short_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == REQ_LOAD || req_type == REQ_TICK)
		|=> req_ready)
		else $error("load or tick held the block busy");

	a_res_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!req_ready))
		else $error("result without an event in flight");
endmodule

bind gated_nearest_centroid_matcher gncm_checker u_gncm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.req_type(req.req_type),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_slot(res.match_slot),
	.res_angle(res.smoothed_azimuth)
);
`default_nettype wire
